/* hdl/particle_smoke_update_macros.svh */
// Assertion macros used by the smoke particle pool checker.
`ifndef PARTICLE_SMOKE_UPDATE_MACROS_SVH
`define PARTICLE_SMOKE_UPDATE_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define PSU_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("particle pool check failed");

// Next-cycle implication, disabled while reset is asserted.
`define PSU_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("particle pool check failed");

`endif

/* hdl/psu_pkg.sv */
// Shared types and constants of the smoke particle pool.
package psu_pkg;

    // Pool size default and fixed field widths.
    localparam int PARTICLE_SLOTS_DEF = 64;
    localparam int RAND_W   = 7;
    localparam int SLOT_W   = 6;
    localparam int COORD_W  = 32;
    localparam int ALPHA_W  = 8;
    localparam int AGE_W    = 16;
    localparam int IN_DATA_W  = 16;
    localparam int OUT_DATA_W = 80;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_TARGET_VX = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TARGET_VY = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_AGE   = 2'd2;

    // Configuration reset values.
    localparam logic signed [COORD_W-1:0] TARGET_VX_RST = 32'sd0;
    localparam logic signed [COORD_W-1:0] TARGET_VY_RST = 32'sd6554;
    localparam logic [AGE_W-1:0]          MAX_AGE_RST   = 16'd10000;

    // Particle constants.
    localparam logic [ALPHA_W-1:0] ALPHA_FULL = 8'd200;
    localparam logic [AGE_W-1:0]   AGE_CAP    = 16'hFFFF;

    // Unsigned 32-bit divide by 100: floor(m * RELAX_MAGIC / 2^RELAX_SHIFT).
    localparam logic [31:0] RELAX_MAGIC = 32'd1374389535;
    localparam int          RELAX_SHIFT = 37;
    localparam int          QUO_W       = 64 - RELAX_SHIFT;

    // One stored particle.
    typedef struct packed {
        logic signed [COORD_W-1:0] pos_x;
        logic signed [COORD_W-1:0] pos_y;
        logic signed [COORD_W-1:0] vel_x;
        logic signed [COORD_W-1:0] vel_y;
        logic [ALPHA_W-1:0]        alpha;
        logic [AGE_W-1:0]          age;
    } slot_rec_t;

    // Stage enables of the kinematics unit.
    typedef struct packed {
        logic load;
        logic mul;
        logic step;
    } kin_ctrl_t;

endpackage

/* hdl/psu_kin.sv */
// Kinematics of one axis: velocity relaxation toward a target and saturating move.
module psu_kin
    import psu_pkg::*;
(
    input  logic                      clk,
    input  kin_ctrl_t                 ctrl,
    input  logic signed [COORD_W-1:0] vel_in,
    input  logic signed [COORD_W-1:0] pos_in,
    input  logic signed [COORD_W-1:0] target,
    output logic signed [COORD_W-1:0] vel_out,
    output logic signed [COORD_W-1:0] pos_out
);

    logic signed [COORD_W-1:0] vel_reg;
    logic signed [COORD_W-1:0] pos_reg;
    logic [COORD_W-1:0]        mag_reg;
    logic                      neg_reg;
    logic [QUO_W-1:0]          quo_reg;

    logic [COORD_W:0]          diff_next;
    logic [COORD_W:0]          diff_neg;
    logic [63:0]               prod_next;
    logic [COORD_W-1:0]        step_next;
    logic [COORD_W-1:0]        quo_ext;
    logic [COORD_W:0]          sum_next;

    // Difference to the target, split into sign and magnitude.
    assign diff_next = {target[COORD_W-1], target} - {vel_in[COORD_W-1], vel_in};
    assign diff_neg  = (~diff_next) + 33'd1;

    // Divide the magnitude by 100 with a reciprocal multiply.
    assign prod_next = 64'(mag_reg) * 64'(RELAX_MAGIC);

    // Signed step, truncated toward zero.
    assign quo_ext   = COORD_W'(quo_reg);
    assign step_next = neg_reg ? ((~quo_ext) + 32'd1) : quo_ext;

    always_ff @(posedge clk)
    begin
        if (ctrl.load)
        begin
            vel_reg <= vel_in;
            pos_reg <= pos_in;
            neg_reg <= diff_next[COORD_W];
            mag_reg <= diff_next[COORD_W] ? diff_neg[COORD_W-1:0]
                                          : diff_next[COORD_W-1:0];
        end
        if (ctrl.mul)
        begin
            quo_reg <= prod_next[63:RELAX_SHIFT];
        end
        if (ctrl.step)
        begin
            vel_reg <= vel_reg + $signed(step_next);
        end
    end

    // Position moves by the new velocity and saturates at the signed limits.
    assign sum_next = {pos_reg[COORD_W-1], pos_reg} + {vel_reg[COORD_W-1], vel_reg};

    always_comb
    begin
        if (sum_next[COORD_W] != sum_next[COORD_W-1])
        begin
            pos_out = sum_next[COORD_W] ? {1'b1, {(COORD_W-1){1'b0}}}
                                        : {1'b0, {(COORD_W-1){1'b1}}};
        end
        else
        begin
            pos_out = sum_next[COORD_W-1:0];
        end
    end

    assign vel_out = vel_reg;

endmodule

/* hdl/particle_smoke_update.sv */
// A frame word walks every slot once. A free slot is only read, but for the one that takes
// the new particle; a live one is read, loaded, multiplied, stepped, written back and, if it
// survives, pushed, all through the single record memory.
// Output stalls stretch the walk; the next frame word is taken while the last result waits.
// Reset clears the slot valid bits, the control state and the configuration registers;
// the record memory is not cleared, since a slot is always written when it is activated.
module particle_smoke_update
    import psu_pkg::*;
#(
    parameter int PARTICLE_SLOTS = PARTICLE_SLOTS_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    // Frame tick words.
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,   // rand_x[6:0], rand_y[13:7], zero pad
    // Particle report words.
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [OUT_DATA_W-1:0] m_axis_tdata,   // slot[5:0], pos_x[37:6], pos_y[69:38],
                                                  // alpha[77:70], zero pad
    output logic                  m_axis_tlast,
    // Configuration writes.
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    localparam int IDX_W = (PARTICLE_SLOTS > 1) ? $clog2(PARTICLE_SLOTS) : 1;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(PARTICLE_SLOTS - 1);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_LOAD,
        ST_MUL,
        ST_STEP,
        ST_WRITE,
        ST_PUSH,
        ST_FLUSH
    } state_t;

    state_t                      state_reg;
    logic [IDX_W-1:0]            idx_reg;
    logic                        spawned_reg;
    logic                        spawn_now_reg;
    logic [PARTICLE_SLOTS-1:0]   active_reg;

    logic signed [COORD_W-1:0]   target_vx_reg;
    logic signed [COORD_W-1:0]   target_vy_reg;
    logic [AGE_W-1:0]            max_age_reg;

    logic signed [COORD_W-1:0]   spawn_vx_reg;
    logic signed [COORD_W-1:0]   spawn_vy_reg;
    logic [ALPHA_W-1:0]          alpha_reg;
    logic [AGE_W-1:0]            age_reg;

    logic [SLOT_W-1:0]           cand_slot_reg;
    logic signed [COORD_W-1:0]   cand_x_reg;
    logic signed [COORD_W-1:0]   cand_y_reg;
    logic [ALPHA_W-1:0]          cand_alpha_reg;

    logic                        pend_valid_reg;
    logic [SLOT_W-1:0]           pend_slot_reg;
    logic signed [COORD_W-1:0]   pend_x_reg;
    logic signed [COORD_W-1:0]   pend_y_reg;
    logic [ALPHA_W-1:0]          pend_alpha_reg;

    logic                        out_valid_reg;
    logic                        out_last_reg;
    logic [OUT_DATA_W-1:0]       out_data_reg;

    slot_rec_t                   mem [PARTICLE_SLOTS];
    slot_rec_t                   rd_reg;
    slot_rec_t                   wr_rec;
    logic                        mem_we;

    kin_ctrl_t                   kin_ctrl;
    logic signed [COORD_W-1:0]   kin_vx_in;
    logic signed [COORD_W-1:0]   kin_vy_in;
    logic signed [COORD_W-1:0]   kin_px_in;
    logic signed [COORD_W-1:0]   kin_py_in;
    logic signed [COORD_W-1:0]   new_vx;
    logic signed [COORD_W-1:0]   new_vy;
    logic signed [COORD_W-1:0]   new_px;
    logic signed [COORD_W-1:0]   new_py;

    logic [ALPHA_W-1:0]          alpha_next;
    logic [AGE_W-1:0]            age_next;
    logic                        free_next;
    logic                        out_free;
    logic                        out_load;
    logic                        in_accept;
    logic [OUT_DATA_W-1:0]       pend_word;

    // Spawn speed x: trunc((rx - 49) * 65.536), with floor(67n / 125) by reciprocal.
    function automatic logic signed [COORD_W-1:0] spawn_vx(input logic [RAND_W-1:0] rx);
        logic        neg;
        logic [6:0]  n;
        logic [12:0] y;
        logic [26:0] p;
        logic [12:0] mag;
        neg = (rx < 7'd49);
        n   = neg ? (7'd49 - rx) : (rx - 7'd49);
        y   = 13'(n) * 13'd67;
        p   = 27'(y) * 27'd8389;
        mag = 13'(n) * 13'd65 + 13'(p[26:20]);
        spawn_vx = neg ? -$signed(32'(mag)) : $signed(32'(mag));
    endfunction

    // Spawn speed y: floor((ry + 50) * 131.072), with floor(9n / 125) by reciprocal.
    function automatic logic signed [COORD_W-1:0] spawn_vy(input logic [RAND_W-1:0] ry);
        logic [7:0]  n;
        logic [10:0] y;
        logic [24:0] p;
        logic [15:0] mag;
        n   = 8'(ry) + 8'd50;
        y   = 11'(n) * 11'd9;
        p   = 25'(y) * 25'd8389;
        mag = 16'(n) * 16'd131 + 16'(p[24:20]);
        spawn_vy = $signed(32'(mag));
    endfunction

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            target_vx_reg <= TARGET_VX_RST;
            target_vy_reg <= TARGET_VY_RST;
            max_age_reg   <= MAX_AGE_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_TARGET_VX: target_vx_reg <= $signed(cfg_data[COORD_W-1:0]);
                CFG_TARGET_VY: target_vy_reg <= $signed(cfg_data[COORD_W-1:0]);
                CFG_MAX_AGE:   max_age_reg   <= cfg_data[AGE_W-1:0];
                default:       ;
            endcase
        end
    end

    // Record memory. A slot is read in ST_READ and written back in ST_WRITE before
    // the walk moves on, so a read never meets a pending write to the same entry.
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[idx_reg] <= wr_rec;
        end
        rd_reg <= mem[idx_reg];
    end

    // Stage enables and operand selection for the two axis units.
    always_comb
    begin
        kin_ctrl.load = (state_reg == ST_LOAD);
        kin_ctrl.mul  = (state_reg == ST_MUL);
        kin_ctrl.step = (state_reg == ST_STEP);
        kin_vx_in = spawn_now_reg ? spawn_vx_reg : rd_reg.vel_x;
        kin_vy_in = spawn_now_reg ? spawn_vy_reg : rd_reg.vel_y;
        kin_px_in = spawn_now_reg ? '0 : rd_reg.pos_x;
        kin_py_in = spawn_now_reg ? '0 : rd_reg.pos_y;
    end

    psu_kin u_kin_x (
        .clk     (clk),
        .ctrl    (kin_ctrl),
        .vel_in  (kin_vx_in),
        .pos_in  (kin_px_in),
        .target  (target_vx_reg),
        .vel_out (new_vx),
        .pos_out (new_px)
    );

    psu_kin u_kin_y (
        .clk     (clk),
        .ctrl    (kin_ctrl),
        .vel_in  (kin_vy_in),
        .pos_in  (kin_py_in),
        .target  (target_vy_reg),
        .vel_out (new_vy),
        .pos_out (new_py)
    );

    // Fading, aging and retirement of the slot being written back.
    always_comb
    begin
        alpha_next = (alpha_reg != '0) ? (alpha_reg - 8'd1) : alpha_reg;
        age_next   = (age_reg != AGE_CAP) ? (age_reg + 16'd1) : age_reg;
        free_next  = (age_next > max_age_reg);
        mem_we     = (state_reg == ST_WRITE);
        wr_rec.pos_x = new_px;
        wr_rec.pos_y = new_py;
        wr_rec.vel_x = new_vx;
        wr_rec.vel_y = new_vy;
        wr_rec.alpha = alpha_next;
        wr_rec.age   = age_next;
    end

    assign out_free  = !out_valid_reg || m_axis_tready;
    assign in_accept = s_axis_tvalid && s_axis_tready;
    assign pend_word = {{(OUT_DATA_W - SLOT_W - 2 * COORD_W - ALPHA_W){1'b0}},
                        pend_alpha_reg, pend_y_reg, pend_x_reg, pend_slot_reg};

    // The held-back word moves to the output register in this cycle.
    assign out_load  = pend_valid_reg && out_free &&
                       ((state_reg == ST_PUSH) || (state_reg == ST_FLUSH));

    // Slot walk sequencer with the held-back result and the output register.
    // One result is held back so that the last live slot of a frame can be marked.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            idx_reg        <= '0;
            spawned_reg    <= 1'b0;
            spawn_now_reg  <= 1'b0;
            active_reg     <= '0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
            out_last_reg   <= 1'b0;
        end
        else
        begin
            if (m_axis_tready && !out_load)
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE:
                begin
                    if (in_accept)
                    begin
                        idx_reg      <= '0;
                        spawned_reg  <= 1'b0;
                        spawn_vx_reg <= spawn_vx(s_axis_tdata[RAND_W-1:0]);
                        spawn_vy_reg <= spawn_vy(s_axis_tdata[2*RAND_W-1:RAND_W]);
                        state_reg    <= ST_READ;
                    end
                end
                ST_READ:
                begin
                    if (active_reg[idx_reg])
                    begin
                        state_reg <= ST_LOAD;
                    end
                    else if (!spawned_reg)
                    begin
                        // Lowest free slot of this frame takes the new particle.
                        spawned_reg   <= 1'b1;
                        spawn_now_reg <= 1'b1;
                        state_reg     <= ST_LOAD;
                    end
                    else if (idx_reg == LAST_IDX)
                    begin
                        state_reg <= ST_FLUSH;
                    end
                    else
                    begin
                        idx_reg <= idx_reg + 1'b1;
                    end
                end
                ST_LOAD:
                begin
                    alpha_reg <= spawn_now_reg ? ALPHA_FULL : rd_reg.alpha;
                    age_reg   <= spawn_now_reg ? '0 : rd_reg.age;
                    state_reg <= ST_MUL;
                end
                ST_MUL:
                begin
                    state_reg <= ST_STEP;
                end
                ST_STEP:
                begin
                    state_reg <= ST_WRITE;
                end
                ST_WRITE:
                begin
                    spawn_now_reg       <= 1'b0;
                    active_reg[idx_reg] <= !free_next;
                    cand_slot_reg       <= SLOT_W'(idx_reg);
                    cand_x_reg          <= new_px;
                    cand_y_reg          <= new_py;
                    cand_alpha_reg      <= alpha_next;
                    if (!free_next)
                    begin
                        state_reg <= ST_PUSH;
                    end
                    else if (idx_reg == LAST_IDX)
                    begin
                        state_reg <= ST_FLUSH;
                    end
                    else
                    begin
                        idx_reg   <= idx_reg + 1'b1;
                        state_reg <= ST_READ;
                    end
                end
                ST_PUSH:
                begin
                    if (!pend_valid_reg || out_free)
                    begin
                        if (pend_valid_reg)
                        begin
                            out_valid_reg <= 1'b1;
                            out_last_reg  <= 1'b0;
                            out_data_reg  <= pend_word;
                        end
                        pend_valid_reg <= 1'b1;
                        pend_slot_reg  <= cand_slot_reg;
                        pend_x_reg     <= cand_x_reg;
                        pend_y_reg     <= cand_y_reg;
                        pend_alpha_reg <= cand_alpha_reg;
                        if (idx_reg == LAST_IDX)
                        begin
                            state_reg <= ST_FLUSH;
                        end
                        else
                        begin
                            idx_reg   <= idx_reg + 1'b1;
                            state_reg <= ST_READ;
                        end
                    end
                end
                ST_FLUSH:
                begin
                    if (!pend_valid_reg)
                    begin
                        state_reg <= ST_IDLE;
                    end
                    else if (out_free)
                    begin
                        out_valid_reg  <= 1'b1;
                        out_last_reg   <= 1'b1;
                        out_data_reg   <= pend_word;
                        pend_valid_reg <= 1'b0;
                        state_reg      <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;
    assign m_axis_tlast  = out_last_reg;

endmodule

/* hdl/psu_check.sv */
// Port-level checker of the smoke particle pool and its bind to the top level.
`include "particle_smoke_update_macros.svh"

module psu_check
    import psu_pkg::*;
(
    input logic                  clk,
    input logic                  rst_n,
    input logic                  s_axis_tvalid,
    input logic                  s_axis_tready,
    input logic                  m_axis_tvalid,
    input logic                  m_axis_tready,
    input logic [OUT_DATA_W-1:0] m_axis_tdata,
    input logic                  m_axis_tlast
);

    // A stalled report word keeps its valid and its contents.
    `PSU_ASSERT_NEXT(a_out_hold, clk, rst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))

    // Taking a frame word starts a slot walk, so the input side closes.
    `PSU_ASSERT_NEXT(a_busy_after_tick, clk, rst_n, s_axis_tvalid && s_axis_tready, !s_axis_tready)

    // A word that is not the frame's last is only shown while the walk still runs.
    `PSU_ASSERT_IMPL(a_mid_frame_busy, clk, rst_n, m_axis_tvalid && !m_axis_tlast, !s_axis_tready)

    // Opacity never exceeds its starting value.
    `PSU_ASSERT_IMPL(a_alpha_range, clk, rst_n, m_axis_tvalid, m_axis_tdata[77:70] <= ALPHA_FULL)

endmodule

bind particle_smoke_update psu_check u_psu_check (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
);

/* verif/tb.sv */
// Self-checking testbench for the smoke particle pool: directed table, random frames, stall pressure.
module tb;
    import psu_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int SLOTS         = PARTICLE_SLOTS_DEF;
    localparam int SETTLE_CYCLES = 500;   // long enough for one full walk of the pool
    localparam int LONG_HOLD     = 1500;
    localparam int MAX_SHOWN     = 10;

    // One particle report word as the block sends it.
    typedef struct packed {
        logic [SLOT_W-1:0]         slot;
        logic signed [COORD_W-1:0] pos_x;
        logic signed [COORD_W-1:0] pos_y;
        logic [ALPHA_W-1:0]        alpha;
        logic                      last;
    } particle_report_t;

    typedef enum logic [0:0] {ROW_FRAME, ROW_CFG} row_op_e;
    typedef enum logic [1:0] {EXP_PREDICT, EXP_ONE, EXP_NONE} row_exp_e;

    // One line of the directed plan: a frame word or a register write.
    typedef struct packed {
        row_op_e               op;
        logic [RAND_W-1:0]     rand_x;
        logic [RAND_W-1:0]     rand_y;
        logic [CFG_IDX_W-1:0]  reg_index;
        logic [CFG_DATA_W-1:0] reg_value;
        row_exp_e              exp_kind;
        particle_report_t      report;
    } plan_row_t;

    localparam int PLAN_ROWS = 28;

    logic                  clk;
    logic                  rst_n;
    logic                  s_axis_tvalid;
    logic                  s_axis_tready;
    logic [IN_DATA_W-1:0]  s_axis_tdata;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready;
    logic [OUT_DATA_W-1:0] m_axis_tdata;
    logic                  m_axis_tlast;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    // Shadow copy of the pool and its registers.
    logic signed [COORD_W-1:0] tgt_vx;
    logic signed [COORD_W-1:0] tgt_vy;
    logic [AGE_W-1:0]          age_limit;
    bit                        pool_live  [SLOTS];
    logic signed [COORD_W-1:0] pool_pos_x [SLOTS];
    logic signed [COORD_W-1:0] pool_pos_y [SLOTS];
    logic signed [COORD_W-1:0] pool_vel_x [SLOTS];
    logic signed [COORD_W-1:0] pool_vel_y [SLOTS];
    logic [ALPHA_W-1:0]        pool_alpha [SLOTS];
    logic [AGE_W-1:0]          pool_age   [SLOTS];

    particle_report_t frame_reports[$];
    particle_report_t pending_reports[$];
    plan_row_t        plan [PLAN_ROWS];

    int fault_count;
    bit quiet_tail;
    bit hold_req;

    particle_smoke_update DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    initial clk = 1'b0;
    always #10 clk = ~clk;

    // Velocity moves a hundredth of the way to the target, rounded toward zero.
    function automatic logic signed [COORD_W-1:0] relax_toward(
        input logic signed [COORD_W-1:0] v,
        input logic signed [COORD_W-1:0] t
    );
        longint step;
        longint next_v;
        step   = (longint'(t) - longint'(v)) / 100;
        next_v = longint'(v) + step;
        return next_v[COORD_W-1:0];
    endfunction

    function automatic logic signed [COORD_W-1:0] sat_sum(
        input logic signed [COORD_W-1:0] a,
        input logic signed [COORD_W-1:0] b
    );
        longint s;
        s = longint'(a) + longint'(b);
        if (s > longint'(32'sh7FFF_FFFF))
            s = longint'(32'sh7FFF_FFFF);
        if (s < longint'(32'sh8000_0000))
            s = longint'(32'sh8000_0000);
        return s[COORD_W-1:0];
    endfunction

    // One frame tick: spawn into the lowest free slot, update, then report survivors.
    function automatic void advance_pool(input logic [RAND_W-1:0] rx, input logic [RAND_W-1:0] ry);
        longint           rxl;
        longint           ryl;
        longint           speed;
        bit               spawned;
        particle_report_t r;
        rxl = rx;
        ryl = ry;
        spawned = 1'b0;
        frame_reports.delete();
        for (int s = 0; s < SLOTS; s++)
        begin
            if (!pool_live[s] && !spawned)
            begin
                spawned = 1'b1;
                pool_live[s]  = 1'b1;
                pool_pos_x[s] = '0;
                pool_pos_y[s] = '0;
                speed = ((rxl - 49) * 65536) / 1000;
                pool_vel_x[s] = speed[COORD_W-1:0];
                speed = ((ryl + 50) * 65536) / 500;
                pool_vel_y[s] = speed[COORD_W-1:0];
                pool_alpha[s] = ALPHA_FULL;
                pool_age[s]   = '0;
            end
        end
        for (int s = 0; s < SLOTS; s++)
        begin
            if (pool_live[s])
            begin
                pool_vel_x[s] = relax_toward(pool_vel_x[s], tgt_vx);
                pool_vel_y[s] = relax_toward(pool_vel_y[s], tgt_vy);
                pool_pos_x[s] = sat_sum(pool_pos_x[s], pool_vel_x[s]);
                pool_pos_y[s] = sat_sum(pool_pos_y[s], pool_vel_y[s]);
                if (pool_alpha[s] != '0)
                    pool_alpha[s] = pool_alpha[s] - 1'b1;
                if (pool_age[s] != AGE_CAP)
                    pool_age[s] = pool_age[s] + 1'b1;
                if (pool_age[s] > age_limit)
                    pool_live[s] = 1'b0;
            end
        end
        for (int s = 0; s < SLOTS; s++)
        begin
            if (pool_live[s])
            begin
                r.slot  = s[SLOT_W-1:0];
                r.pos_x = pool_pos_x[s];
                r.pos_y = pool_pos_y[s];
                r.alpha = pool_alpha[s];
                r.last  = 1'b0;
                frame_reports.push_back(r);
            end
        end
        if (frame_reports.size() > 0)
            frame_reports[frame_reports.size() - 1].last = 1'b1;
    endfunction

    function automatic plan_row_t frame_row(
        input logic [RAND_W-1:0] rx,
        input logic [RAND_W-1:0] ry,
        input row_exp_e          kind = EXP_PREDICT,
        input particle_report_t  report = '0
    );
        return '{ROW_FRAME, rx, ry, CFG_TARGET_VX, '0, kind, report};
    endfunction

    function automatic plan_row_t cfg_row(
        input logic [CFG_IDX_W-1:0]  idx,
        input logic [CFG_DATA_W-1:0] value
    );
        return '{ROW_CFG, '0, '0, idx, value, EXP_NONE, '0};
    endfunction

    // Offer one frame word, maybe after a gap, and predict once it is taken.
    task automatic send_frame(
        input logic [RAND_W-1:0] rx,
        input logic [RAND_W-1:0] ry,
        input row_exp_e          kind,
        input particle_report_t  report
    );
        int gap;
        @(negedge clk);
        if (!quiet_tail && $urandom_range(0, 3) == 0)
        begin
            s_axis_tvalid <= 1'b0;
            gap = $urandom_range(1, 19);
            repeat (gap) @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {2'b00, ry, rx};
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        advance_pool(rx, ry);
        case (kind)
            EXP_ONE:  pending_reports.push_back(report);
            EXP_NONE: ;
            default:  foreach (frame_reports[i]) pending_reports.push_back(frame_reports[i]);
        endcase
    endtask

    // Draws are mostly in range, sometimes in the unused top of the field.
    task automatic send_random_frame();
        logic [RAND_W-1:0] rx;
        logic [RAND_W-1:0] ry;
        rx = ($urandom_range(0, 7) == 0) ? RAND_W'($urandom_range(100, 127))
                                         : RAND_W'($urandom_range(0, 99));
        ry = ($urandom_range(0, 7) == 0) ? RAND_W'($urandom_range(100, 127))
                                         : RAND_W'($urandom_range(0, 99));
        send_frame(rx, ry, EXP_PREDICT, '0);
    endtask

    // Stop offering words and let the block run dry.
    task automatic finish_phase();
        @(negedge clk);
        s_axis_tvalid <= 1'b0;
        while (pending_reports.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] value);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        case (idx)
            CFG_TARGET_VX: tgt_vx = value;
            CFG_TARGET_VY: tgt_vy = value;
            CFG_MAX_AGE:   age_limit = value[AGE_W-1:0];
            default: ;
        endcase
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    // Output ready: random stall bursts, one long hold on request, none at the tail.
    initial
    begin : report_sink
        int n;
        m_axis_tready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_req)
            begin
                m_axis_tready <= 1'b0;
                repeat (LONG_HOLD - 1) @(negedge clk);
                hold_req = 1'b0;
            end
            else if (!quiet_tail && $urandom_range(0, 11) == 0)
            begin
                m_axis_tready <= 1'b0;
                n = $urandom_range(1, 19);
                repeat (n - 1) @(negedge clk);
            end
            else
            begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    // Compare every accepted report word with the oldest expectation.
    always @(posedge clk)
    begin : report_check
        particle_report_t seen;
        particle_report_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            seen.slot  = m_axis_tdata[5:0];
            seen.pos_x = m_axis_tdata[37:6];
            seen.pos_y = m_axis_tdata[69:38];
            seen.alpha = m_axis_tdata[77:70];
            seen.last  = m_axis_tlast;
            if (pending_reports.size() == 0)
            begin
                fault_count++;
                if (fault_count <= MAX_SHOWN)
                    $display("%0t: unexpected report word, slot %0d", $realtime, seen.slot);
            end
            else
            begin
                want = pending_reports.pop_front();
                if (seen.slot != want.slot || seen.pos_x != want.pos_x ||
                    seen.pos_y != want.pos_y || seen.alpha != want.alpha ||
                    seen.last != want.last)
                begin
                    fault_count++;
                    if (fault_count <= MAX_SHOWN)
                    begin
                        $write("%0t: report mismatch (expected/actual) slot %0d/%0d ",
                               $realtime, want.slot, seen.slot);
                        $display("x %0d/%0d y %0d/%0d alpha %0d/%0d last %0b/%0b",
                                 want.pos_x, seen.pos_x, want.pos_y, seen.pos_y,
                                 want.alpha, seen.alpha, want.last, seen.last);
                    end
                end
            end
        end
    end

    // Main sequence: reset, directed plan, then three random phases.
    initial
    begin : stimulus
        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        cfg_we        = 1'b0;
        cfg_index     = '0;
        cfg_data      = '0;
        fault_count   = 0;
        quiet_tail    = 1'b0;
        hold_req      = 1'b0;
        tgt_vx        = TARGET_VX_RST;
        tgt_vy        = TARGET_VY_RST;
        age_limit     = MAX_AGE_RST;
        foreach (pool_live[s])
            pool_live[s] = 1'b0;

        plan = '{
            // First frame after reset: one particle, only the vertical speed is nonzero.
            frame_row(7'd49, 7'd0, EXP_ONE, '{6'd0, 32'sd0, 32'sd6553, 8'd199, 1'b1}),
            frame_row(7'd0, 7'd0),
            frame_row(7'd99, 7'd99),
            frame_row(7'd127, 7'd127),
            frame_row(7'd0, 7'd127),
            frame_row(7'd127, 7'd0),
            frame_row(7'd85, 7'd42),
            frame_row(7'd42, 7'd85),
            // A zero lifetime frees every slot, the new one included.
            cfg_row(CFG_MAX_AGE, 32'd0),
            frame_row(7'd10, 7'd20, EXP_NONE),
            frame_row(7'd99, 7'd0, EXP_NONE),
            // Extreme targets with endless lifetime drive positions into saturation.
            cfg_row(CFG_TARGET_VX, 32'h7FFF_FFFF),
            cfg_row(CFG_TARGET_VY, 32'h8000_0000),
            cfg_row(CFG_MAX_AGE, 32'd65535),
            frame_row(7'd0, 7'd0),
            frame_row(7'd99, 7'd99),
            frame_row(7'd1, 7'd2),
            frame_row(7'd64, 7'd32),
            frame_row(7'd16, 7'd8),
            frame_row(7'd4, 7'd127),
            frame_row(7'd50, 7'd49),
            frame_row(7'd48, 7'd51),
            frame_row(7'd100, 7'd100),
            frame_row(7'd63, 7'd31),
            frame_row(7'd126, 7'd1),
            frame_row(7'd2, 7'd126),
            frame_row(7'd77, 7'd11),
            frame_row(7'd33, 7'd66)
        };

        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        foreach (plan[k])
        begin
            if (plan[k].op == ROW_CFG)
            begin
                finish_phase();
                write_reg(plan[k].reg_index, plan[k].reg_value);
            end
            else
            begin
                send_frame(plan[k].rand_x, plan[k].rand_y, plan[k].exp_kind, plan[k].report);
            end
        end

        // Keep the saturating setup until the pool is full; hold the output once.
        for (int k = 0; k < 56; k++)
        begin
            if (k == 30)
                hold_req = 1'b1;
            send_random_frame();
        end

        // Short lifetimes with the opposite extremes.
        finish_phase();
        write_reg(CFG_TARGET_VX, 32'h8000_0000);
        write_reg(CFG_TARGET_VY, 32'h7FFF_FFFF);
        write_reg(CFG_MAX_AGE, CFG_DATA_W'($urandom_range(1, 30)));
        for (int k = 0; k < 10; k++)
            send_random_frame();

        // Random targets, with no idling on either side.
        finish_phase();
        write_reg(CFG_TARGET_VX, $urandom);
        write_reg(CFG_TARGET_VY, $urandom);
        write_reg(CFG_MAX_AGE, CFG_DATA_W'($urandom_range(40, 65534)));
        quiet_tail = 1'b1;
        for (int k = 0; k < 10; k++)
            send_random_frame();

        finish_phase();
        if (fault_count == 0 && pending_reports.size() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

    // Watchdog for a hung handshake.
    initial
    begin : watchdog
        #20ms;
        $display("FAIL");
        $finish;
    end

endmodule

/* sim.f */
+incdir+hdl
hdl/psu_pkg.sv
hdl/psu_kin.sv
hdl/particle_smoke_update.sv
hdl/psu_check.sv
verif/tb.sv
